// ----- rtl/ipvsi_pkg.sv -----
// Shared constants, codes and types of the incremental PID controller.
// Depends on nothing; the other design files but ipvsi_chk use it by scoped names.
package ipvsi_pkg;

	// Channel state depth and field widths.
	localparam int CHANNELS = 4;
	localparam int CH_W = 2;
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DATA_W = 16;

	// Configuration port.
	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_KP    = 3'd0,
		REG_KI    = 3'd1,
		REG_KD    = 3'd2,
		REG_BLEND = 3'd3,
		REG_VSI   = 3'd4,
		REG_LIMIT = 3'd5
	} reg_idx_t;

	localparam logic [8:0]  BLEND_ONE   = 9'd256;
	localparam logic [14:0] LIMIT_RESET = 15'd800;

	// Serial multiplier: two multiplier bits are retired per cycle.
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = 48;

	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic               busy;
		logic [MUL_P_W-1:0] p;
	} mul_rsp_t;

	// Reciprocal divider: 2^32 / den, den in [2^16, 2^32).
	localparam int DIV_D_W = 32;
	localparam int DIV_Q_W = 17;
	localparam int DIV_CNT_W = 5;
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd17;
	localparam logic [DIV_D_W-1:0] DIV_R_INIT = 32'h0000_8000;
	localparam logic [DIV_D_W-1:0] VSI_ONE = 32'h0001_0000;

	typedef struct packed {
		logic               start;
		logic [DIV_D_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic [DIV_Q_W-1:0] quo;
	} div_rsp_t;

	// Main sequencer: error, reciprocal and integral chain.
	typedef enum logic [3:0] {
		M_IDLE,
		M_PREP,
		M_VSI,
		M_DIV,
		M_CE,
		M_KI,
		M_JOIN,
		M_INC,
		M_CLAMP,
		M_DONE
	} main_state_t;

	// Side sequencer: derivative and proportional chain.
	typedef enum logic [2:0] {
		X_IDLE,
		X_KD,
		X_DPRE,
		X_BLEND,
		X_KP,
		X_DONE
	} side_state_t;

endpackage

// ----- rtl/ipvsi_if.sv -----
// Channel interfaces of the incremental PID controller: samples, results and
// configuration writes, each with valid and ready. Depends on ipvsi_pkg.
interface ipvsi_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ipvsi_pkg::DATA_W-1:0]  setpoint;
	logic signed [ipvsi_pkg::DATA_W-1:0]  measured;
	logic        [ipvsi_pkg::CH_W-1:0]    channel;

	modport source (output valid, setpoint, measured, channel, input ready);
	modport sink   (input valid, setpoint, measured, channel, output ready);
endinterface

interface ipvsi_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ipvsi_pkg::DATA_W-1:0]  drive_sum;
	logic        [ipvsi_pkg::CH_W-1:0]    channel_out;

	modport source (output valid, drive_sum, channel_out, input ready);
	modport sink   (input valid, drive_sum, channel_out, output ready);
endinterface

interface ipvsi_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [ipvsi_pkg::REG_IDX_W-1:0]      index;
	logic [ipvsi_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/incremental_pid_vsi_filtered.sv -----
// Top level of the per-channel incremental PID controller with variable-speed
// integral and filtered derivative. Depends on ipvsi_pkg, the channel
// interfaces, ipvsi_smul and ipvsi_div.
//
//   Channel  Direction  Carries                              Accepted when
//   sample   in         setpoint, measured, channel          valid && ready
//   result   out        drive_sum, channel_out               valid && ready
//   cfg      in         index, data (register write)         valid && ready
//
// One item is worked on at a time, and the main chain sets the pace: a serial
// multiply of the speed coefficient by |error|, the 17-step reciprocal divider
// and two more serial multiplies for the integral. Each serial multiply ends
// early when its multiplier operand has zero upper bits.
// Reset is asynchronous, active low, and initialises the configuration
// registers, the sequencers, the output valid flag and the channel state.
// A finished result waits in the output register; the next item is accepted
// meanwhile and only its own completion waits for the register to empty.
module incremental_pid_vsi_filtered (
	input  logic         clk,
	input  logic         arst_n,
	ipvsi_in_if.sink     sample,
	ipvsi_out_if.source  result,
	ipvsi_cfg_if.sink    cfg
);

	// Configuration registers.
	logic [15:0] kp_q;
	logic [15:0] ki_q;
	logic [15:0] kd_q;
	logic [8:0]  blend_q;
	logic [15:0] vsi_q;
	logic [14:0] limit_q;

	// Per-channel controller state. The derivative history never exceeds
	// 24 bits, since it is a blend of values bounded by kd*dmeas/256.
	logic [16:0] perr_q  [ipvsi_pkg::CHANNELS];
	logic [15:0] pmeas_q [ipvsi_pkg::CHANNELS];
	logic [23:0] hist_q  [ipvsi_pkg::CHANNELS];
	logic [15:0] acc_q   [ipvsi_pkg::CHANNELS];

	// Sequencers.
	ipvsi_pkg::main_state_t state_q, state_d;
	ipvsi_pkg::side_state_t side_q, side_d;

	// Item registers and intermediate results.
	logic [15:0] ms_q;
	logic [1:0]  ch_q;
	logic [16:0] e_q;
	logic        skip_q;
	logic [15:0] ae_q;
	logic        dm_neg_q;
	logic [16:0] de_mag_q;
	logic        de_neg_q;
	logic [23:0] dpre_q;
	logic        dh_neg_q;
	logic [33:0] x_q;
	logic [23:0] dout_q;
	logic [32:0] pkp_q;
	logic [47:0] pki_q;
	logic [50:0] num_q;
	logic [26:0] inc_q;
	logic [15:0] sum_q;

	// Output register.
	logic        out_valid_q;
	logic [15:0] out_sum_q;
	logic [1:0]  out_ch_q;

	// Combinational helpers.
	logic [ipvsi_pkg::CH_IDX_W-1:0] idx;
	logic        in_acc;
	logic        chan_ok;
	logic        load_out;
	logic [16:0] ae_w;
	logic [16:0] dm_w;
	logic [16:0] dm_mag_w;
	logic [17:0] de_w;
	logic [17:0] de_mag_w;
	logic [15:0] kd_mag;
	logic [15:0] ki_mag;
	logic [15:0] kp_mag;
	logic [8:0]  blend_eff;
	logic [22:0] dpre_mag;
	logic [23:0] dpre_w;
	logic [24:0] dh_w;
	logic [24:0] dh_mag_w;
	logic [33:0] bprod_w;
	logic [33:0] x_w;
	logic [33:0] xr_w;
	logic [50:0] num_w;
	logic [50:0] numr_w;
	logic signed [27:0] sum_w;
	logic signed [27:0] lim_w;
	logic signed [27:0] nlim_w;

	ipvsi_pkg::mul_req_t mul0_req, mul1_req;
	ipvsi_pkg::mul_rsp_t mul0_rsp, mul1_rsp;
	ipvsi_pkg::div_req_t div_req;
	ipvsi_pkg::div_rsp_t div_rsp;

	ipvsi_smul u_mul_main (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul0_req),
		.rsp    (mul0_rsp)
	);

	ipvsi_smul u_mul_side (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul1_req),
		.rsp    (mul1_rsp)
	);

	ipvsi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ------------------------------------------------------------------
	// Configuration writes. The port never stalls; writes are to be made
	// only while no item is in flight, so no item sees a register change
	// under it.
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= '0;
			ki_q    <= '0;
			kd_q    <= '0;
			blend_q <= ipvsi_pkg::BLEND_ONE;
			vsi_q   <= '0;
			limit_q <= ipvsi_pkg::LIMIT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (ipvsi_pkg::reg_idx_t'(cfg.index))
				ipvsi_pkg::REG_KP:    kp_q    <= cfg.data;
				ipvsi_pkg::REG_KI:    ki_q    <= cfg.data;
				ipvsi_pkg::REG_KD:    kd_q    <= cfg.data;
				ipvsi_pkg::REG_BLEND: blend_q <= cfg.data[8:0];
				ipvsi_pkg::REG_VSI:   vsi_q   <= cfg.data;
				ipvsi_pkg::REG_LIMIT: limit_q <= cfg.data[14:0];
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Operand preparation. Gains are used as sign and magnitude so that the
	// serial multipliers stay unsigned; truncation toward zero then falls
	// out of shifting the magnitude.
	// ------------------------------------------------------------------
	assign idx     = ch_q[ipvsi_pkg::CH_IDX_W-1:0];
	assign in_acc  = sample.valid && sample.ready;
	assign chan_ok = (32'(sample.channel) < ipvsi_pkg::CHANNELS);

	assign kd_mag = kd_q[15] ? (16'd0 - kd_q) : kd_q;
	assign ki_mag = ki_q[15] ? (16'd0 - ki_q) : ki_q;
	assign kp_mag = kp_q[15] ? (16'd0 - kp_q) : kp_q;

	// Blend weights above one behave as exactly one.
	assign blend_eff = (blend_q > ipvsi_pkg::BLEND_ONE) ? ipvsi_pkg::BLEND_ONE : blend_q;

	// Error magnitude, measurement change and error change of this item.
	assign ae_w     = e_q[16] ? (17'd0 - e_q) : e_q;
	assign dm_w     = {ms_q[15], ms_q} - {pmeas_q[idx][15], pmeas_q[idx]};
	assign dm_mag_w = dm_w[16] ? (17'd0 - dm_w) : dm_w;
	assign de_w     = {e_q[16], e_q} - {perr_q[idx][16], perr_q[idx]};
	assign de_mag_w = de_w[17] ? (18'd0 - de_w) : de_w;

	// The pre-filter derivative is -kd*dmeas/256: its sign is the opposite
	// of the product's, and its magnitude is the product's shifted down.
	assign dpre_mag = mul1_rsp.p[30:8];
	assign dpre_w   = (kd_q[15] ^ dm_neg_q) ? {1'b0, dpre_mag} : (24'd0 - {1'b0, dpre_mag});

	// The low-pass is rewritten as 256*hist + blend*(dpre - hist), which
	// needs only one multiply.
	assign dh_w     = {dpre_q[23], dpre_q} - {hist_q[idx][23], hist_q[idx]};
	assign dh_mag_w = dh_w[24] ? (25'd0 - dh_w) : dh_w;
	assign bprod_w  = {1'b0, mul1_rsp.p[32:0]};
	assign x_w      = {{2{hist_q[idx][23]}}, hist_q[idx], 8'd0}
		+ (dh_neg_q ? (34'd0 - bprod_w) : bprod_w);

	// Signed division by 256 toward zero: bias negative values before the
	// arithmetic shift.
	assign xr_w = x_q + (x_q[33] ? 34'd255 : 34'd0);

	// Increment numerator, all three terms aligned at 2^-24.
	assign num_w = {{2{pkp_q[32]}}, pkp_q[32:0], 16'd0}
		+ {{3{pki_q[47]}}, pki_q}
		+ {{3{dout_q[23]}}, dout_q, 24'd0};
	assign numr_w = num_q + (num_q[50] ? 51'h0_0000_00FF_FFFF : 51'd0);

	// Saturation against the symmetric bound.
	assign sum_w  = $signed({inc_q[26], inc_q}) + $signed({{12{acc_q[idx][15]}}, acc_q[idx]});
	assign lim_w  = $signed({13'd0, limit_q});
	assign nlim_w = -lim_w;

	// ------------------------------------------------------------------
	// Main sequencer: reciprocal weight C = 2^32/(65536 + vsi*|e|), then
	// C*|e| and that times |ki|, then the sum, truncation and saturation.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ipvsi_pkg::M_IDLE;
			side_q  <= ipvsi_pkg::X_IDLE;
		end else begin
			state_q <= state_d;
			side_q  <= side_d;
		end
	end

	assign load_out = (state_q == ipvsi_pkg::M_DONE) && (!out_valid_q || result.ready);

	always_comb begin
		state_d       = state_q;
		mul0_req      = '0;
		div_req       = '0;
		sample.ready  = 1'b0;
		unique case (state_q)
			ipvsi_pkg::M_IDLE: begin
				sample.ready = 1'b1;
				if (sample.valid) begin
					state_d = chan_ok ? ipvsi_pkg::M_PREP : ipvsi_pkg::M_DONE;
				end
			end
			ipvsi_pkg::M_PREP: begin
				mul0_req.start = 1'b1;
				mul0_req.a     = {16'd0, ae_w[15:0]};
				mul0_req.b     = vsi_q;
				state_d        = ipvsi_pkg::M_VSI;
			end
			ipvsi_pkg::M_VSI: begin
				if (!mul0_rsp.busy) begin
					div_req.start = 1'b1;
					div_req.den   = ipvsi_pkg::VSI_ONE + mul0_rsp.p[31:0];
					state_d       = ipvsi_pkg::M_DIV;
				end
			end
			ipvsi_pkg::M_DIV: begin
				if (!div_rsp.busy) begin
					mul0_req.start = 1'b1;
					mul0_req.a     = {15'd0, div_rsp.quo};
					mul0_req.b     = ae_q;
					state_d        = ipvsi_pkg::M_CE;
				end
			end
			ipvsi_pkg::M_CE: begin
				if (!mul0_rsp.busy) begin
					mul0_req.start = 1'b1;
					mul0_req.a     = mul0_rsp.p[31:0];
					mul0_req.b     = ki_mag;
					state_d        = ipvsi_pkg::M_KI;
				end
			end
			ipvsi_pkg::M_KI: begin
				if (!mul0_rsp.busy) begin
					state_d = ipvsi_pkg::M_JOIN;
				end
			end
			ipvsi_pkg::M_JOIN: begin
				if (side_q == ipvsi_pkg::X_DONE) begin
					state_d = ipvsi_pkg::M_INC;
				end
			end
			ipvsi_pkg::M_INC: begin
				state_d = ipvsi_pkg::M_CLAMP;
			end
			ipvsi_pkg::M_CLAMP: begin
				state_d = ipvsi_pkg::M_DONE;
			end
			ipvsi_pkg::M_DONE: begin
				if (load_out) begin
					state_d = ipvsi_pkg::M_IDLE;
				end
			end
			default: begin
				state_d = ipvsi_pkg::M_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Side sequencer: derivative on the measurement, its low-pass, then the
	// proportional product. It runs alongside the divider and meets the
	// main sequencer in M_JOIN.
	// ------------------------------------------------------------------
	always_comb begin
		side_d   = side_q;
		mul1_req = '0;
		unique case (side_q)
			ipvsi_pkg::X_IDLE: begin
				if (state_q == ipvsi_pkg::M_PREP) begin
					mul1_req.start = 1'b1;
					mul1_req.a     = {16'd0, dm_mag_w[15:0]};
					mul1_req.b     = kd_mag;
					side_d         = ipvsi_pkg::X_KD;
				end
			end
			ipvsi_pkg::X_KD: begin
				if (!mul1_rsp.busy) begin
					side_d = ipvsi_pkg::X_DPRE;
				end
			end
			ipvsi_pkg::X_DPRE: begin
				mul1_req.start = 1'b1;
				mul1_req.a     = {8'd0, dh_mag_w[23:0]};
				mul1_req.b     = {7'd0, blend_eff};
				side_d         = ipvsi_pkg::X_BLEND;
			end
			ipvsi_pkg::X_BLEND: begin
				if (!mul1_rsp.busy) begin
					mul1_req.start = 1'b1;
					mul1_req.a     = {15'd0, de_mag_q};
					mul1_req.b     = kp_mag;
					side_d         = ipvsi_pkg::X_KP;
				end
			end
			ipvsi_pkg::X_KP: begin
				if (!mul1_rsp.busy) begin
					side_d = ipvsi_pkg::X_DONE;
				end
			end
			ipvsi_pkg::X_DONE: begin
				if (state_q == ipvsi_pkg::M_JOIN) begin
					side_d = ipvsi_pkg::X_IDLE;
				end
			end
			default: begin
				side_d = ipvsi_pkg::X_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Datapath registers, loaded as the sequencers pass through.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ms_q   <= sample.measured;
			ch_q   <= sample.channel;
			e_q    <= {sample.setpoint[15], sample.setpoint}
				- {sample.measured[15], sample.measured};
			skip_q <= !chan_ok;
		end
		if (state_q == ipvsi_pkg::M_PREP) begin
			ae_q     <= ae_w[15:0];
			dm_neg_q <= dm_w[16];
			de_mag_q <= de_mag_w[16:0];
			de_neg_q <= de_w[17];
		end
		if ((state_q == ipvsi_pkg::M_KI) && !mul0_rsp.busy) begin
			pki_q <= (e_q[16] ^ ki_q[15]) ? (48'd0 - {1'b0, mul0_rsp.p[46:0]})
				: {1'b0, mul0_rsp.p[46:0]};
		end
		if (state_q == ipvsi_pkg::M_JOIN) begin
			num_q <= num_w;
		end
		if (state_q == ipvsi_pkg::M_INC) begin
			inc_q <= numr_w[50:24];
		end
		if (in_acc && !chan_ok) begin
			sum_q <= '0;
		end else if (state_q == ipvsi_pkg::M_CLAMP) begin
			if (sum_w > lim_w) begin
				sum_q <= lim_w[15:0];
			end else if (sum_w < nlim_w) begin
				sum_q <= nlim_w[15:0];
			end else begin
				sum_q <= sum_w[15:0];
			end
		end

		if ((side_q == ipvsi_pkg::X_KD) && !mul1_rsp.busy) begin
			dpre_q <= dpre_w;
		end
		if (side_q == ipvsi_pkg::X_DPRE) begin
			dh_neg_q <= dh_w[24];
		end
		if ((side_q == ipvsi_pkg::X_BLEND) && !mul1_rsp.busy) begin
			x_q <= x_w;
		end
		if (side_q == ipvsi_pkg::X_KP) begin
			dout_q <= xr_w[31:8];
			if (!mul1_rsp.busy) begin
				pkp_q <= (de_neg_q ^ kp_q[15]) ? (33'd0 - {1'b0, mul1_rsp.p[31:0]})
					: {1'b0, mul1_rsp.p[31:0]};
			end
		end
	end

	// ------------------------------------------------------------------
	// Channel state update. The previous measurement is replaced only after
	// this item's derivative has used it. An out-of-range channel leaves all
	// state as it was.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ipvsi_pkg::CHANNELS; i++) begin
				perr_q[i]  <= '0;
				pmeas_q[i] <= '0;
				hist_q[i]  <= '0;
				acc_q[i]   <= '0;
			end
		end else if (load_out && !skip_q) begin
			perr_q[idx]  <= e_q;
			pmeas_q[idx] <= ms_q;
			hist_q[idx]  <= dout_q;
			acc_q[idx]   <= sum_q;
		end
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_sum_q <= sum_q;
			out_ch_q  <= ch_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.drive_sum   = out_sum_q;
	assign result.channel_out = out_ch_q;

endmodule

// ----- rtl/ipvsi_smul.sv -----
// Digit-serial unsigned multiplier, two multiplier bits per cycle.
// Depends on ipvsi_pkg for widths and the request and response structs.
module ipvsi_smul (
	input  logic                clk,
	input  logic                arst_n,
	input  ipvsi_pkg::mul_req_t req,
	output ipvsi_pkg::mul_rsp_t rsp
);

	logic [ipvsi_pkg::MUL_P_W-1:0] a_q;
	logic [ipvsi_pkg::MUL_P_W-1:0] acc_q;
	logic [ipvsi_pkg::MUL_B_W-1:0] b_q;
	logic [ipvsi_pkg::MUL_P_W-1:0] pp0;
	logic [ipvsi_pkg::MUL_P_W-1:0] pp1;

	// The multiplicand moves up two places as the multiplier moves down two.
	assign pp0 = b_q[0] ? a_q : '0;
	assign pp1 = b_q[1] ? {a_q[ipvsi_pkg::MUL_P_W-2:0], 1'b0} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q <= '0;
		end else if (req.start) begin
			b_q <= req.b;
		end else begin
			b_q <= b_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= {{(ipvsi_pkg::MUL_P_W - ipvsi_pkg::MUL_A_W){1'b0}}, req.a};
			acc_q <= '0;
		end else if (b_q != '0) begin
			a_q   <= {a_q[ipvsi_pkg::MUL_P_W-3:0], 2'b00};
			acc_q <= acc_q + pp0 + pp1;
		end
	end

	assign rsp.busy = (b_q != '0);
	assign rsp.p    = acc_q;

endmodule

// ----- rtl/ipvsi_div.sv -----
// Restoring divider that forms 2^32 / den one quotient bit per cycle.
// Depends on ipvsi_pkg for widths and the request and response structs.
module ipvsi_div (
	input  logic                clk,
	input  logic                arst_n,
	input  ipvsi_pkg::div_req_t req,
	output ipvsi_pkg::div_rsp_t rsp
);

	logic [ipvsi_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [ipvsi_pkg::DIV_D_W-1:0]   r_q;
	logic [ipvsi_pkg::DIV_D_W-1:0]   d_q;
	logic [ipvsi_pkg::DIV_Q_W-1:0]   q_q;
	logic [ipvsi_pkg::DIV_D_W:0]     trial;
	logic [ipvsi_pkg::DIV_D_W+1:0]   diff;
	logic                            fits;

	// The quotient is below 2^17, so the dividend's upper part seeds the
	// remainder and only its seventeen zero bits remain to be brought down.
	assign trial = {r_q, 1'b0};
	assign diff  = {1'b0, trial} - {2'b00, d_q};
	assign fits  = !diff[ipvsi_pkg::DIV_D_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= ipvsi_pkg::DIV_STEPS;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q <= ipvsi_pkg::DIV_R_INIT;
			d_q <= req.den;
			q_q <= '0;
		end else if (cnt_q != '0) begin
			r_q <= fits ? diff[ipvsi_pkg::DIV_D_W-1:0] : trial[ipvsi_pkg::DIV_D_W-1:0];
			q_q <= {q_q[ipvsi_pkg::DIV_Q_W-2:0], fits};
		end
	end

	assign rsp.busy = (cnt_q != '0);
	assign rsp.quo  = q_q;

endmodule

// ----- rtl/ipvsi_chk.sv -----
// Port-level checks of the incremental PID controller, bound to its top level.
// Depends on the top level's channel interfaces through the bind below.
module ipvsi_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  in_channel,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] drive_sum,
	input logic [1:0]  channel_out
);

	logic [1:0] last_ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ch_q <= '0;
		end else if (in_valid && in_ready) begin
			last_ch_q <= in_channel;
		end
	end

	// One item at a time: after an acceptance the input is closed.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted again straight after an item");

	// The saturated sum never reaches the most negative code.
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive_sum != 16'h8000)
		else $error("result outside the saturation range");

	// A new result belongs to the item accepted last.
	a_channel: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> channel_out == last_ch_q)
		else $error("result channel differs from the last accepted item");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive_sum) && $stable(channel_out))
		else $error("stalled result changed");

endmodule

bind incremental_pid_vsi_filtered ipvsi_chk u_ipvsi_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (sample.valid),
	.in_ready    (sample.ready),
	.in_channel  (sample.channel),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.drive_sum   (result.drive_sum),
	.channel_out (result.channel_out)
);

// ----- tb/ipvsi_drive_checker.sv -----
// Checker of the incremental PID controller: watches the sample, result and
// configuration channels, predicts each drive sum and compares it with the block.
// Depends on ipvsi_pkg and the channel interfaces of ipvsi_if.sv.
module ipvsi_drive_checker (
	input  logic  clk,
	input  logic  arst_n,
	ipvsi_in_if   sample,
	ipvsi_out_if  result,
	ipvsi_cfg_if  cfg,
	output int    mismatches,
	output int    waiting
);
	timeunit 1ns;
	timeprecision 1ps;
	import ipvsi_pkg::*;

	typedef struct {
		logic signed [DATA_W-1:0] drive_sum;
		logic        [CH_W-1:0]   channel;
	} drive_t;

	localparam longint RECIP_NUM = 64'sd4294967296;
	localparam longint Q16_ONE   = 64'sd65536;
	localparam longint Q24_ONE   = 64'sd16777216;

	// Register copies, updated on every accepted configuration write.
	logic signed [DATA_W-1:0] kp;
	logic signed [DATA_W-1:0] ki;
	logic signed [DATA_W-1:0] kd;
	logic        [8:0]        blend;
	logic        [15:0]       vsi;
	logic        [14:0]       limit;

	// Per-channel controller history.
	logic signed [DATA_W:0]   err_mem   [CHANNELS];
	logic signed [DATA_W-1:0] meas_mem  [CHANNELS];
	logic signed [31:0]       deriv_mem [CHANNELS];
	logic signed [DATA_W-1:0] acc_mem   [CHANNELS];

	drive_t drive_queue [$];
	drive_t want;

	task automatic report_mismatch(input string what);
		$display("[%0t] drive check: %s", $time, what);
		mismatches++;
	endtask

	// Works out the saturated sum of one item and moves the channel history on.
	function automatic drive_t next_drive(input logic signed [DATA_W-1:0] sp,
		input logic signed [DATA_W-1:0] ms, input logic [CH_W-1:0] ch);
		drive_t r;
		longint err, mag, recip, dpre, wt, dout, num, total, bound;
		r.channel = ch;
		r.drive_sum = '0;
		if (ch >= CHANNELS)
			return r;
		err = longint'(sp) - longint'(ms);
		mag = (err < 0) ? -err : err;
		recip = RECIP_NUM / (Q16_ONE + longint'(vsi) * mag);
		dpre = -(longint'(kd) * (longint'(ms) - longint'(meas_mem[ch]))) / 256;
		wt = (blend > BLEND_ONE) ? 64'sd256 : longint'(blend);
		dout = ((256 - wt) * longint'(deriv_mem[ch]) + wt * dpre) / 256;
		num = longint'(kp) * (err - longint'(err_mem[ch])) * Q16_ONE
			+ recip * longint'(ki) * err
			+ dout * Q24_ONE;
		total = longint'(acc_mem[ch]) + num / Q24_ONE;
		bound = longint'(limit);
		if (total > bound)
			total = bound;
		if (total < -bound)
			total = -bound;
		acc_mem[ch] = total[DATA_W-1:0];
		err_mem[ch] = err[DATA_W:0];
		meas_mem[ch] = ms;
		deriv_mem[ch] = dout[31:0];
		r.drive_sum = total[DATA_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp = '0;
			ki = '0;
			kd = '0;
			blend = BLEND_ONE;
			vsi = '0;
			limit = LIMIT_RESET;
			for (int i = 0; i < CHANNELS; i++) begin
				err_mem[i] = '0;
				meas_mem[i] = '0;
				deriv_mem[i] = '0;
				acc_mem[i] = '0;
			end
			drive_queue.delete();
			mismatches = 0;
		end else begin
			// Results are compared before this edge's item is queued: the
			// two can never belong together.
			if (result.valid && result.ready) begin
				if (drive_queue.size() == 0) begin
					report_mismatch($sformatf("unexpected result, channel %0d sum %0d",
						result.channel_out, result.drive_sum));
				end else begin
					want = drive_queue.pop_front();
					if (result.drive_sum !== want.drive_sum)
						report_mismatch($sformatf("channel %0d sum %0d, predicted %0d",
							want.channel, result.drive_sum, want.drive_sum));
					if (result.channel_out !== want.channel)
						report_mismatch($sformatf("channel_out %0d, predicted %0d",
							result.channel_out, want.channel));
				end
			end
			if (sample.valid && sample.ready)
				drive_queue.push_back(next_drive(sample.setpoint, sample.measured,
					sample.channel));
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				REG_KP:    kp = cfg.data;
				REG_KI:    ki = cfg.data;
				REG_KD:    kd = cfg.data;
				REG_BLEND: blend = cfg.data[8:0];
				REG_VSI:   vsi = cfg.data;
				REG_LIMIT: limit = cfg.data[14:0];
				default:   ;
				endcase
			end
		end
		waiting = drive_queue.size();
	end

endmodule

// ----- tb/testbench.sv -----
// Top of the controller testbench: clock, reset, stimulus and the verdict.
// Depends on ipvsi_pkg, the channel interfaces, the block and ipvsi_drive_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ipvsi_pkg::*;

	// The limit leaves several times what the slowest correct run, of roughly
	// 1850 items, needs.
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 305;
	localparam int IDLE_PCT      = 36;
	localparam int TAIL_CYCLES   = 60;

	logic        clk;
	logic        arst_n;
	int          fail_count;
	int          open_items;
	int unsigned cycle_count = 0;
	int          send_idle = IDLE_PCT;
	int          sink_idle = IDLE_PCT;

	ipvsi_in_if  sample_ch ();
	ipvsi_out_if result_ch ();
	ipvsi_cfg_if cfg_ch ();

	incremental_pid_vsi_filtered DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// The checker sees the same three channels as the block and reports back
	// how many results have gone wrong and how many are still owed.
	ipvsi_drive_checker drive_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample_ch),
		.result     (result_ch),
		.cfg        (cfg_ch),
		.mismatches (fail_count),
		.waiting    (open_items)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// A runaway run is stopped here; a correct one never gets near the limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// The result side stalls at random, independently of the sender. Setting
	// sink_idle to zero gives a stretch in which every result leaves at once.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= ($urandom_range(0, 99) >= sink_idle);
		end
	end

	// Presents one item, with a random number of idle cycles in front of it,
	// and returns at the falling edge after the item has been accepted. Valid
	// is left high, so back-to-back items keep it high without a glitch.
	task automatic put_sample(input logic [15:0] sp, input logic [15:0] ms,
		input logic [1:0] ch);
		while ($urandom_range(0, 99) < send_idle) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.setpoint <= sp;
		sample_ch.measured <= ms;
		sample_ch.channel <= ch;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		@(negedge clk);
	endtask

	// Lowers valid and waits until every item sent so far has its result back.
	// At least one edge always passes, so valid is never driven twice in a step.
	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (open_items != 0);
	endtask

	// One register write; valid stays high so that writes can follow each
	// other, and the caller lowers it after the last one.
	task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	// Registers only change once the block has gone quiet: all results in,
	// then a short pause so that the last one has fully left the block.
	task automatic apply_settings(input logic [15:0] kp, input logic [15:0] ki,
		input logic [15:0] kd, input logic [8:0] blend, input logic [15:0] vsi,
		input logic [14:0] lim);
		drain_results();
		repeat (4) @(negedge clk);
		write_reg(REG_KP, kp);
		write_reg(REG_KI, ki);
		write_reg(REG_KD, kd);
		write_reg(REG_BLEND, {7'd0, blend});
		write_reg(REG_VSI, vsi);
		write_reg(REG_LIMIT, {1'b0, lim});
		cfg_ch.valid <= 1'b0;
	endtask

	// A third of the gains are moderate so that the sum moves inside its
	// bounds; the two extremes and the full range make up the rest.
	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 5))
		0:       return 16'h7FFF;
		1:       return 16'h8000;
		2, 3:    return 16'($urandom);
		default: return 16'($urandom_range(0, 2047) - 1024);
		endcase
	endfunction

	// Blend weights above one must behave exactly as one.
	function automatic logic [8:0] pick_blend();
		case ($urandom_range(0, 3))
		0:       return 9'd0;
		1:       return BLEND_ONE;
		2:       return 9'($urandom_range(257, 511));
		default: return 9'($urandom_range(0, 256));
		endcase
	endfunction

	// Small coefficients keep the integral weight near one for most errors;
	// large ones cut it down hard.
	function automatic logic [15:0] pick_vsi();
		case ($urandom_range(0, 3))
		0:       return 16'd0;
		1:       return 16'hFFFF;
		2:       return 16'($urandom_range(1, 64));
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [14:0] pick_limit();
		case ($urandom_range(0, 3))
		0:       return 15'd0;
		1:       return 15'h7FFF;
		2:       return LIMIT_RESET;
		default: return 15'($urandom_range(1, 32767));
		endcase
	endfunction

	function automatic logic [15:0] pick_edge();
		case ($urandom_range(0, 3))
		0:       return 16'h7FFF;
		1:       return 16'h8000;
		2:       return 16'h0000;
		default: return 16'($urandom);
		endcase
	endfunction

	// Half of the items follow a setpoint closely, as a settled loop would,
	// the rest cover the full range and its edges.
	task automatic random_sample(output logic [15:0] sp, output logic [15:0] ms,
		output logic [1:0] ch);
		int base;
		ch = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 3))
		0, 1: begin
			base = int'($urandom_range(0, 4000)) - 2000;
			sp = 16'(base);
			ms = 16'(base + int'($urandom_range(0, 128)) - 64);
		end
		2: begin
			sp = 16'($urandom);
			ms = 16'($urandom);
		end
		default: begin
			sp = pick_edge();
			ms = pick_edge();
		end
		endcase
	endtask

	initial begin
		logic [15:0] sp;
		logic [15:0] ms;
		logic [1:0]  ch;

		sample_ch.valid = 1'b0;
		sample_ch.setpoint = '0;
		sample_ch.measured = '0;
		sample_ch.channel = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, first setting: only the gains are written, so the
		// blend, speed coefficient and limit keep their reset values. The first
		// item on each channel sees the step from the cleared history.
		write_reg(REG_KP, 16'h0100);
		write_reg(REG_KI, 16'h0080);
		write_reg(REG_KD, 16'hFE00);
		cfg_ch.valid <= 1'b0;
		put_sample(16'd100, 16'd40, 2'd0);
		put_sample(16'hFED4, 16'd250, 2'd1);
		put_sample(16'h7FFF, 16'h8000, 2'd2);
		put_sample(16'h8000, 16'h7FFF, 2'd3);
		put_sample(16'd100, 16'd100, 2'd0);
		put_sample(16'h0000, 16'h0000, 2'd0);
		put_sample(16'h7FFF, 16'h7FFF, 2'd2);
		put_sample(16'hFFFF, 16'h0001, 2'd1);

		// Extreme gains, a blend weight above one, the largest speed
		// coefficient and the widest limit.
		apply_settings(16'h8000, 16'h7FFF, 16'h7FFF, 9'd511, 16'hFFFF, 15'h7FFF);
		put_sample(16'h7FFF, 16'h8000, 2'd0);
		put_sample(16'h8000, 16'h7FFF, 2'd0);
		put_sample(16'h0000, 16'h0000, 2'd1);
		put_sample(16'h8000, 16'h8000, 2'd1);
		put_sample(16'h1234, 16'hEDCC, 2'd3);
		put_sample(16'h8000, 16'h7FFF, 2'd2);
		put_sample(16'h7FFF, 16'h0000, 2'd3);

		// The opposite extremes with a zero limit: every sum is clamped to
		// zero, while the derivative history must still follow the rules.
		apply_settings(16'h7FFF, 16'h8000, 16'h8000, 9'd0, 16'h0001, 15'd0);
		put_sample(16'h8000, 16'h7FFF, 2'd0);
		put_sample(16'h7FFF, 16'h8000, 2'd1);
		put_sample(16'h0000, 16'hFFFF, 2'd2);
		put_sample(16'h55AA, 16'hAA55, 2'd3);
		put_sample(16'h0000, 16'h0000, 2'd0);
		put_sample(16'h7FFF, 16'h7FFF, 2'd1);

		// Random part: a fresh setting for each phase. The third phase runs
		// with no idling on either side, and halfway through the fourth the
		// sender holds off until the block has handed back everything.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			apply_settings(pick_gain(), pick_gain(), pick_gain(), pick_blend(),
				pick_vsi(), pick_limit());
			send_idle = (phase == 2) ? 0 : IDLE_PCT;
			sink_idle = (phase == 2) ? 0 : IDLE_PCT;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 3 && n == PHASE_ITEMS / 2)
					drain_results();
				random_sample(sp, ms, ch);
				put_sample(sp, ms, ch);
			end
		end

		// Let the last results out, then watch a little longer for any
		// stray result before giving the verdict.
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && open_items == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
